FILE: hdl/frame_quadrant_fingerprint_top_macros.svh
// Assertion macros for the frame quadrant fingerprint checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FRAME_QUADRANT_FINGERPRINT_TOP_MACROS_SVH
`define FRAME_QUADRANT_FINGERPRINT_TOP_MACROS_SVH

// Same-cycle implication.
`define FQF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fingerprint checker: property violated");

// Next-cycle implication.
`define FQF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fingerprint checker: property violated");

`endif

FILE: hdl/fqf_pkg.sv
// Shared types, constants and functions of the frame quadrant fingerprint.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fqf_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXB   = 2'd2;
    localparam logic [1:0] REG_STRIDE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADCFG = 2'd1;
    localparam logic [1:0] ST_SHORT  = 2'd2;

    typedef logic [7:0][12:0] t_axis;

    typedef struct packed {
        logic take_in;
        logic hash_step;
        logic glob_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic hash_last;
        logic glob_last;
    } t_sts;

    // floor(n / 3), exact for n below 24576
    function automatic logic [12:0] div3(input logic [14:0] n);
        logic [28:0] p;
        p = {14'd0, n} * 29'd10923;
        return p[27:15];
    endfunction

    // Sample coordinates along one axis: low half in 0..3, high half in 4..7
    function automatic t_axis place_axis(input logic [12:0] size);
        t_axis       a;
        logic [12:0] half;
        logic [12:0] d0;
        logic [12:0] d1;
        logic [14:0] n0;
        logic [14:0] n1;
        half = size >> 1;
        d0   = (size >= 13'd2) ? half - 13'd1 : 13'd0;
        d1   = size - 13'd1 - half;
        for (int s = 0; s < 4; s++) begin
            n0 = {2'b00, d0} * 15'(s);
            n1 = {2'b00, d1} * 15'(s);
            a[s]     = (size == 13'd0) ? 13'd0 : div3(n0);
            a[s + 4] = (size == 13'd0) ? 13'd0 : half + div3(n1);
        end
        return a;
    endfunction

    // First entry holding the value; found flag in the top bit
    function automatic logic [3:0] first_match_idx(input t_axis a, input logic [12:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 7; i >= 0; i--) begin
            if (a[i] == v) begin
                r = {1'b1, 3'(i)};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/fqf_ctrl.sv
// Phase controller of the frame quadrant fingerprint.
// Depends on fqf_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module fqf_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_last_byte,
    input  wire            i_out_stall,
    input  fqf_pkg::t_sts  i_sts,
    output fqf_pkg::t_cmd  o_cmd,
    output logic           o_in_stall,
    output logic           o_out_valid
);

    typedef enum logic [1:0] {S_IN, S_HASH, S_GLOB, S_WAIT} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IN);
    assign o_out_valid = r_out_valid;

    // Decode commands for the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.take_in   = (r_state == S_IN) && i_in_valid;
        o_cmd.hash_step = (r_state == S_HASH) && !i_sts.err;
        o_cmd.glob_step = (r_state == S_GLOB);
        o_cmd.load_out  = (r_state == S_WAIT) && out_free;
    end

    // Next phase and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IN: begin
                if (i_in_valid && i_last_byte) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.err) begin
                    n_state = S_WAIT;
                end else if (i_sts.hash_last) begin
                    n_state = S_GLOB;
                end
            end
            S_GLOB: begin
                if (i_sts.glob_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IN;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/fqf_datapath.sv
// Datapath: configuration, frame position, sample store and FNV-1a unit.
// Depends on fqf_pkg; driven by fqf_ctrl through a command struct.
`timescale 1ns / 1ps
`default_nettype none
module fqf_datapath #(
    parameter int MAX_DIM         = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_we,
    input  wire  [1:0]     i_cfg_idx,
    input  wire  [15:0]    i_cfg_data,
    input  wire  [7:0]     i_frame_byte,
    input  wire            i_last_byte,
    input  fqf_pkg::t_cmd  i_cmd,
    output fqf_pkg::t_sts  o_sts,
    output logic [31:0]    o_quadrant0_hash,
    output logic [31:0]    o_quadrant1_hash,
    output logic [31:0]    o_quadrant2_hash,
    output logic [31:0]    o_quadrant3_hash,
    output logic [31:0]    o_global_hash,
    output logic [1:0]     o_status
);

    localparam int KW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int DEPTH = 64 << KW;
    localparam int AW    = 6 + KW;

    // Configuration registers
    logic [12:0] r_width, r_height;
    logic [3:0]  r_pixb;
    logic [15:0] r_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_pixb   <= '0;
            r_stride <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fqf_pkg::REG_WIDTH:  r_width  <= i_cfg_data[12:0];
                fqf_pkg::REG_HEIGHT: r_height <= i_cfg_data[12:0];
                fqf_pkg::REG_PIXB:   r_pixb   <= i_cfg_data[3:0];
                fqf_pkg::REG_STRIDE: r_stride <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sample coordinates and configuration check
    fqf_pkg::t_axis cols, rows;
    logic [16:0]    row_bytes;
    logic           cfg_ok;

    assign cols      = fqf_pkg::place_axis(r_width);
    assign rows      = fqf_pkg::place_axis(r_height);
    assign row_bytes = {4'd0, r_width} * {13'd0, r_pixb};
    assign cfg_ok    = (r_width != '0) && (r_height != '0) && (r_pixb != '0)
                    && (32'(r_width) <= 32'(MAX_DIM)) && (32'(r_height) <= 32'(MAX_DIM))
                    && (32'(r_pixb) <= 32'(MAX_PIXEL_BYTES))
                    && ({1'b0, r_stride} >= row_bytes);

    // Frame position
    logic [15:0] r_bir, n_bir;
    logic [12:0] r_row, n_row;
    logic [12:0] r_x, n_x;
    logic [3:0]  r_k, n_k;
    logic [1:0]  r_status;
    logic        in_frame, cap;
    logic [16:0] bir_inc;
    logic [3:0]  wr_r, wr_c;
    logic [AW-1:0] wr_addr;

    assign in_frame = cfg_ok && (r_row < r_height);
    assign bir_inc  = {1'b0, r_bir} + 17'd1;
    assign wr_r     = fqf_pkg::first_match_idx(rows, r_row);
    assign wr_c     = fqf_pkg::first_match_idx(cols, r_x);
    assign cap      = i_cmd.take_in && in_frame && (r_x < r_width) && wr_r[3] && wr_c[3]
                   && (32'(r_k) < 32'(MAX_PIXEL_BYTES));
    assign wr_addr  = {wr_r[2:0], wr_c[2:0], r_k[KW-1:0]};

    // Pixel column holds at the row width through the padding
    always_comb begin
        n_bir = r_bir;
        n_row = r_row;
        n_x   = r_x;
        n_k   = r_k;
        if (in_frame) begin
            if (bir_inc >= {1'b0, r_stride}) begin
                n_bir = '0;
                n_row = r_row + 13'd1;
                n_x   = '0;
                n_k   = '0;
            end else begin
                n_bir = bir_inc[15:0];
                if (r_k + 4'd1 == r_pixb) begin
                    n_k = '0;
                    n_x = (r_x < r_width) ? r_x + 13'd1 : r_x;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bir    <= '0;
            r_row    <= '0;
            r_x      <= '0;
            r_k      <= '0;
            r_status <= fqf_pkg::ST_OK;
        end else if (i_cmd.take_in) begin
            if (i_last_byte) begin
                r_bir <= '0;
                r_row <= '0;
                r_x   <= '0;
                r_k   <= '0;
                if (!cfg_ok) begin
                    r_status <= fqf_pkg::ST_BADCFG;
                end else if (n_row < r_height) begin
                    r_status <= fqf_pkg::ST_SHORT;
                end else begin
                    r_status <= fqf_pkg::ST_OK;
                end
            end else begin
                r_bir <= n_bir;
                r_row <= n_row;
                r_x   <= n_x;
                r_k   <= n_k;
            end
        end
    end

    // Hash sequencing counters
    logic [1:0]  r_q, r_sy, r_sx;
    logic [4:0]  r_j;
    logic [3:0]  r_gi;
    logic [31:0] r_h, r_glob;
    logic [3:0][31:0] r_qh;
    logic [4:0]  j_end;
    logic        sample_end;

    assign j_end      = 5'd4 + {1'b0, r_pixb};
    assign sample_end = (r_j == j_end);

    // Sample store read, registered ahead of use
    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [12:0]   s_x, s_y;
    logic [3:0]    rd_r, rd_c;
    logic [4:0]    rd_k;
    logic [AW-1:0] rd_addr;

    assign s_x     = cols[{r_q[0], r_sx}];
    assign s_y     = rows[{r_q[1], r_sy}];
    assign rd_r    = fqf_pkg::first_match_idx(rows, s_y);
    assign rd_c    = fqf_pkg::first_match_idx(cols, s_x);
    assign rd_k    = (r_j < 5'd4) ? 5'd0 : r_j - 5'd4;
    assign rd_addr = {rd_r[2:0], rd_c[2:0], rd_k[KW-1:0]};

    always_ff @(posedge i_clk) begin
        if (cap) begin
            mem[wr_addr] <= i_frame_byte;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Byte fed to the FNV unit
    logic [7:0]  hb, gb;
    logic [31:0] h_mix, g_mix, gword;

    always_comb begin
        priority case (1'b1)
            r_j == 5'd0: hb = s_x[7:0];
            r_j == 5'd1: hb = {3'd0, s_x[12:8]};
            r_j == 5'd2: hb = s_y[7:0];
            r_j == 5'd3: hb = {3'd0, s_y[12:8]};
            r_j == 5'd4: hb = {6'd0, r_q};
            default:     hb = r_rd_data;
        endcase
    end

    assign gword = r_qh[r_gi[3:2]];
    assign gb    = gword[8*r_gi[1:0] +: 8];
    assign h_mix = (r_h ^ {24'd0, hb}) * fqf_pkg::FNV_PRIME;
    assign g_mix = (r_glob ^ {24'd0, gb}) * fqf_pkg::FNV_PRIME;

    // Step quadrant hashes, then the global hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= '0;
            r_sy   <= '0;
            r_sx   <= '0;
            r_j    <= '0;
            r_gi   <= '0;
            r_h    <= fqf_pkg::FNV_BASIS;
            r_glob <= fqf_pkg::FNV_BASIS;
            r_qh   <= {4{fqf_pkg::FNV_BASIS}};
        end else if (i_cmd.take_in && i_last_byte) begin
            r_q    <= '0;
            r_sy   <= '0;
            r_sx   <= '0;
            r_j    <= '0;
            r_gi   <= '0;
            r_h    <= fqf_pkg::FNV_BASIS;
            r_glob <= fqf_pkg::FNV_BASIS;
        end else if (i_cmd.hash_step) begin
            if (!sample_end) begin
                r_j <= r_j + 5'd1;
                r_h <= h_mix;
            end else begin
                r_j  <= '0;
                r_sx <= r_sx + 2'd1;
                if (r_sx == 2'd3) begin
                    r_sy <= r_sy + 2'd1;
                end
                if (r_sx == 2'd3 && r_sy == 2'd3) begin
                    r_qh[r_q] <= h_mix;
                    r_h       <= fqf_pkg::FNV_BASIS;
                    r_q       <= r_q + 2'd1;
                end else begin
                    r_h <= h_mix;
                end
            end
        end else if (i_cmd.glob_step) begin
            r_glob <= g_mix;
            r_gi   <= r_gi + 4'd1;
        end
    end

    assign o_sts.err       = (r_status != fqf_pkg::ST_OK);
    assign o_sts.hash_last = sample_end && (r_sx == 2'd3) && (r_sy == 2'd3) && (r_q == 2'd3);
    assign o_sts.glob_last = (r_gi == 4'd15);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status <= r_status;
            if (r_status != fqf_pkg::ST_OK) begin
                o_quadrant0_hash <= '0;
                o_quadrant1_hash <= '0;
                o_quadrant2_hash <= '0;
                o_quadrant3_hash <= '0;
                o_global_hash    <= '0;
            end else begin
                o_quadrant0_hash <= r_qh[0];
                o_quadrant1_hash <= r_qh[1];
                o_quadrant2_hash <= r_qh[2];
                o_quadrant3_hash <= r_qh[3];
                o_global_hash    <= r_glob;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/frame_quadrant_fingerprint_top.sv
// Frame quadrant fingerprint: takes frame bytes one per cycle and, on the byte marked last,
// delivers four sparse FNV-1a quadrant hashes, a global hash and a status. Bytes stream in at
// one per cycle. After the last byte the input stalls while the block hashes: with a good
// status the quadrant FNV multiply-xor unit mixes one byte per cycle over the 64 samples,
// then a second unit folds the 16 bytes of the quadrant hashes into the global hash, and the
// result register is loaded (held back only while an earlier result still waits); on an
// error status both hash passes are skipped. The result register lets the next frame start
// while a result still waits. Built from fqf_ctrl and fqf_datapath.
`timescale 1ns / 1ps
`default_nettype none
module frame_quadrant_fingerprint_top #(
    parameter int MAX_DIM         = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_frame_byte,
    input  wire         i_last_byte,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_quadrant0_hash,
    output logic [31:0] o_quadrant1_hash,
    output logic [31:0] o_quadrant2_hash,
    output logic [31:0] o_quadrant3_hash,
    output logic [31:0] o_global_hash,
    output logic [1:0]  o_status
);

    fqf_pkg::t_cmd cmd;
    fqf_pkg::t_sts sts;

    fqf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    fqf_datapath #(
        .MAX_DIM         (MAX_DIM),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_frame_byte     (i_frame_byte),
        .i_last_byte      (i_last_byte),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_quadrant0_hash (o_quadrant0_hash),
        .o_quadrant1_hash (o_quadrant1_hash),
        .o_quadrant2_hash (o_quadrant2_hash),
        .o_quadrant3_hash (o_quadrant3_hash),
        .o_global_hash    (o_global_hash),
        .o_status         (o_status)
    );

endmodule
`default_nettype wire

FILE: hdl/fqf_checker.sv
// Port-level checker for frame_quadrant_fingerprint_top, attached by bind.
// Depends on frame_quadrant_fingerprint_top_macros.svh and fqf_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_quadrant_fingerprint_top_macros.svh"
module fqf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        i_last_byte,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [31:0] o_quadrant0_hash,
    input wire [31:0] o_quadrant1_hash,
    input wire [31:0] o_quadrant2_hash,
    input wire [31:0] o_quadrant3_hash,
    input wire [31:0] o_global_hash,
    input wire [1:0]  o_status
);

    // A stalled result stays offered
    `FQF_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    // Error results carry zero hashes
    `FQF_ASSERT_IMP(a_err_zero, o_out_valid && o_status != fqf_pkg::ST_OK,
        (o_quadrant0_hash | o_quadrant1_hash | o_quadrant2_hash | o_quadrant3_hash
         | o_global_hash) == 32'd0)
    // Status never shows the unused code
    `FQF_ASSERT_IMP(a_status_code, o_out_valid, o_status <= fqf_pkg::ST_SHORT)
    // A last-byte transfer starts the hash pass, so input stalls next
    `FQF_ASSERT_NXT(a_busy_after_last, i_in_valid && !o_in_stall && i_last_byte, o_in_stall)

endmodule

bind frame_quadrant_fingerprint_top fqf_checker u_fqf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_last_byte      (i_last_byte),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_quadrant0_hash (o_quadrant0_hash),
    .o_quadrant1_hash (o_quadrant1_hash),
    .o_quadrant2_hash (o_quadrant2_hash),
    .o_quadrant3_hash (o_quadrant3_hash),
    .o_global_hash    (o_global_hash),
    .o_status         (o_status)
);
`default_nettype wire

FILE: bench/frame_quadrant_fingerprint_top_test.sv
// Self-checking bench for frame_quadrant_fingerprint_top: streams frames, predicts the
// quadrant and global fingerprints with its own model, and compares every result transfer.
// Depends on fqf_pkg and the frame_quadrant_fingerprint_top RTL.
`timescale 1ns / 1ps
module frame_quadrant_fingerprint_top_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_BYTES   = 1250;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = fqf_pkg::REG_WIDTH;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_frame_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_quadrant0_hash, o_quadrant1_hash, o_quadrant2_hash, o_quadrant3_hash;
    logic [31:0] o_global_hash;
    logic [1:0]  o_status;

    frame_quadrant_fingerprint_top dut (.*);

    typedef struct {
        logic [31:0] quad [4];
        logic [31:0] glob;
        logic [1:0]  st;
    } t_print;

    // Directed row: a register write or one byte; typed rows carry a known error status
    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [15:0] value;
        bit          last;
        bit          typed;
        logic [1:0]  st;
    } t_row;

    localparam int N_ROWS = 19;
    localparam t_row ROWS [N_ROWS] = '{
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h00ff, 1'b1, 1'b1, fqf_pkg::ST_BADCFG}, // still zero
        '{1'b1, fqf_pkg::REG_WIDTH,  16'd2,    1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b1, fqf_pkg::REG_HEIGHT, 16'd2,    1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b1, fqf_pkg::REG_PIXB,   16'd1,    1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b1, fqf_pkg::REG_STRIDE, 16'd3,    1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0000, 1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h00ff, 1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h00aa, 1'b0, 1'b0, fqf_pkg::ST_OK},    // padding
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0055, 1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0001, 1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0080, 1'b1, 1'b0, fqf_pkg::ST_OK},
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0012, 1'b1, 1'b1, fqf_pkg::ST_SHORT}, // one byte
        '{1'b1, fqf_pkg::REG_STRIDE, 16'd1,    1'b0, 1'b0, fqf_pkg::ST_OK},    // stride low
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0034, 1'b1, 1'b1, fqf_pkg::ST_BADCFG},
        '{1'b1, fqf_pkg::REG_WIDTH,  16'h1fff, 1'b0, 1'b0, fqf_pkg::ST_OK},    // width high
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0056, 1'b1, 1'b1, fqf_pkg::ST_BADCFG},
        '{1'b1, fqf_pkg::REG_WIDTH,  16'd1,    1'b0, 1'b0, fqf_pkg::ST_OK},
        '{1'b1, fqf_pkg::REG_PIXB,   16'd15,   1'b0, 1'b0, fqf_pkg::ST_OK},    // pixel high
        '{1'b0, fqf_pkg::REG_WIDTH,  16'h0078, 1'b1, 1'b1, fqf_pkg::ST_BADCFG}
    };

    // Predictor state
    int          m_width, m_height, m_pixb, m_stride;
    int          m_col, m_row;
    int          m_rows [8];
    int          m_cols [8];
    logic [7:0]  m_pix [64][8];

    t_print      pending_prints [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          random_sent = 0;

    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
        return (h ^ {24'd0, v[7:0]}) * fqf_pkg::FNV_PRIME;
    endfunction

    function automatic void spread_axis(output int dst [8], input int n);
        int lo, hi;
        for (int half = 0; half < 2; half++) begin
            if (n == 0) begin
                for (int s = 0; s < 4; s++) dst[half * 4 + s] = 0;
            end else begin
                lo = half ? n / 2 : 0;
                hi = half ? n - 1 : n / 2 - 1;
                if (hi < lo) hi = lo;
                if (lo >= n) lo = n - 1;
                if (hi >= n) hi = n - 1;
                for (int s = 0; s < 4; s++) dst[half * 4 + s] = lo + (hi - lo) * s / 3;
            end
        end
    endfunction

    function automatic bit setup_ok();
        if (m_width == 0 || m_height == 0 || m_pixb == 0) return 0;
        if (m_width > 4096 || m_height > 4096 || m_pixb > 8) return 0;
        return m_stride >= m_width * m_pixb;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] v);
        case (idx)
            fqf_pkg::REG_WIDTH:  m_width  = v[12:0];
            fqf_pkg::REG_HEIGHT: m_height = v[12:0];
            fqf_pkg::REG_PIXB:   m_pixb   = v[3:0];
            fqf_pkg::REG_STRIDE: m_stride = v;
            default: ;
        endcase
        spread_axis(m_cols, m_width);
        spread_axis(m_rows, m_height);
    endfunction

    // Advance the frame position by one byte; return 1 with the print on the last byte
    function automatic bit fingerprint_byte(input logic [7:0] b, input bit last,
                                            output t_print p);
        bit          ok;
        int          x, k, r, c;
        logic [31:0] h, g;
        ok = setup_ok();
        if (ok && m_row < m_height) begin
            if (m_col < m_width * m_pixb) begin
                x = m_col / m_pixb;
                k = m_col % m_pixb;
                for (int rr = 0; rr < 8; rr++)
                    for (int cc = 0; cc < 8; cc++)
                        if (m_rows[rr] == m_row && m_cols[cc] == x && k < 8)
                            m_pix[rr * 8 + cc][k] = b;
            end
            m_col++;
            if (m_col >= m_stride) begin
                m_col = 0;
                m_row++;
            end
        end
        if (!last) return 0;
        p.st = !ok ? fqf_pkg::ST_BADCFG : (m_row < m_height) ? fqf_pkg::ST_SHORT
                                                              : fqf_pkg::ST_OK;
        p.glob = '0;
        for (int q = 0; q < 4; q++) p.quad[q] = '0;
        if (p.st == fqf_pkg::ST_OK) begin
            g = fqf_pkg::FNV_BASIS;
            for (int q = 0; q < 4; q++) begin
                h = fqf_pkg::FNV_BASIS;
                for (int sy = 0; sy < 4; sy++) begin
                    r = (q >> 1) * 4 + sy;
                    for (int sx = 0; sx < 4; sx++) begin
                        c = (q & 1) * 4 + sx;
                        h = fnv_mix(h, m_cols[c]);
                        h = fnv_mix(h, m_cols[c] >> 8);
                        h = fnv_mix(h, m_rows[r]);
                        h = fnv_mix(h, m_rows[r] >> 8);
                        h = fnv_mix(h, q);
                        for (int kk = 0; kk < m_pixb && kk < 8; kk++)
                            h = fnv_mix(h, m_pix[r * 8 + c][kk]);
                    end
                end
                p.quad[q] = h;
                g = fnv_mix(g, h);
                g = fnv_mix(g, h >> 8);
                g = fnv_mix(g, h >> 16);
                g = fnv_mix(g, h >> 24);
            end
            p.glob = g;
        end
        m_col = 0;
        m_row = 0;
        return 1;
    endfunction

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check result transfers against the oldest prediction
    always @(posedge i_clk) begin
        t_print e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_prints.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = pending_prints.pop_front();
                if (o_quadrant0_hash !== e.quad[0]) begin
                    $error("quadrant0_hash exp %h got %h", e.quad[0], o_quadrant0_hash);
                    errors++;
                end
                if (o_quadrant1_hash !== e.quad[1]) begin
                    $error("quadrant1_hash exp %h got %h", e.quad[1], o_quadrant1_hash);
                    errors++;
                end
                if (o_quadrant2_hash !== e.quad[2]) begin
                    $error("quadrant2_hash exp %h got %h", e.quad[2], o_quadrant2_hash);
                    errors++;
                end
                if (o_quadrant3_hash !== e.quad[3]) begin
                    $error("quadrant3_hash exp %h got %h", e.quad[3], o_quadrant3_hash);
                    errors++;
                end
                if (o_global_hash !== e.glob) begin
                    $error("global_hash exp %h got %h", e.glob, o_global_hash);
                    errors++;
                end
                if (o_status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** frame_quadrant_fingerprint_top: FAILED **");
            $finish;
        end
    end

    // Send one byte; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                             input logic [1:0] st);
        t_print p;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (fingerprint_byte(b, last, p)) begin
            if (typed) begin
                p.st = st;
                p.glob = '0;
                for (int q = 0; q < 4; q++) p.quad[q] = '0;
            end
            pending_prints.push_back(p);
        end
        @(negedge i_clk);
    endtask

    // Drain results, then write one register while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        i_in_valid <= 1'b0;
        while (pending_prints.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, v);
    endtask

    task automatic set_format(input int w, input int h, input int pb, input int s);
        write_reg(fqf_pkg::REG_WIDTH, 16'(w));
        write_reg(fqf_pkg::REG_HEIGHT, 16'(h));
        write_reg(fqf_pkg::REG_PIXB, 16'(pb));
        write_reg(fqf_pkg::REG_STRIDE, 16'(s));
    endtask

    // Send a frame of n bytes with the last one marked
    task automatic send_frame(input int n, input bit counted);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), i == n - 1, 1'b0, fqf_pkg::ST_OK);
            if (counted) random_sent++;
        end
    endtask

    initial begin
        int w, h, pb, s, len, frames;
        m_width = 0; m_height = 0; m_pixb = 0; m_stride = 0;
        m_col = 0; m_row = 0;
        spread_axis(m_cols, 0);
        spread_axis(m_rows, 0);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows
        for (int i = 0; i < N_ROWS; i++) begin
            if (ROWS[i].is_cfg)
                write_reg(ROWS[i].idx, ROWS[i].value);
            else
                send_byte(ROWS[i].value[7:0], ROWS[i].last, ROWS[i].typed, ROWS[i].st);
        end

        // Largest sizes as short frames; full frames with coordinates past one byte and with 8-byte pixels
        set_format(4096, 1, 1, 4096);
        send_frame(3, 1'b0);
        set_format(1, 4096, 1, 1);
        send_frame(5, 1'b0);
        set_format(4096, 4096, 8, 65535);
        send_frame(3, 1'b0);
        set_format(300, 1, 1, 300);
        send_frame(301, 1'b0);
        set_format(1, 260, 1, 1);
        send_frame(260, 1'b0);
        set_format(1, 1, 8, 8);
        send_frame(8, 1'b0);

        // Random frames under three idling modes
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 50 : 0;
            recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 16 : 0;
            while (random_sent < RANDOM_BYTES * (mode + 1) / 3) begin
                w  = $urandom_range(1, 7);
                h  = $urandom_range(1, 7);
                pb = $urandom_range(1, 8);
                s  = w * pb + $urandom_range(0, 3);
                case ($urandom_range(9))
                    0: w = 0;
                    1: h = 0;
                    2: pb = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
                    3: s = w * pb - 1;
                    default: ;
                endcase
                set_format(w, h, pb, s);
                frames = $urandom_range(1, 4);
                for (int f = 0; f < frames; f++) begin
                    len = (s > 0 && h > 0) ? s * h : $urandom_range(1, 20);
                    if ($urandom_range(99) < 15 && len > 1)
                        len = $urandom_range(1, len - 1);
                    else
                        len = len + $urandom_range(0, 2);
                    send_frame(len, 1'b1);
                end
            end
        end

        // Drain and report
        i_in_valid <= 1'b0;
        while (pending_prints.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("** frame_quadrant_fingerprint_top: PASSED **");
        else
            $display("** frame_quadrant_fingerprint_top: FAILED **");
        $finish;
    end
endmodule

FILE: frame_quadrant_fingerprint_top.f
+incdir+hdl
hdl/fqf_pkg.sv
hdl/fqf_ctrl.sv
hdl/fqf_datapath.sv
hdl/frame_quadrant_fingerprint_top.sv
hdl/fqf_checker.sv
bench/frame_quadrant_fingerprint_top_test.sv
